@@ rtl/mfdp_pkg.sv @@
// mfdp_pkg: types, codes and a helper function for the multipart form-data parser
// used by every module of the parser; no dependencies
package mfdp_pkg;

    localparam int BOUNDARY_MAX = 56;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_BYTE = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [2:0] TAG_NAME   = 3'd0;
    localparam logic [2:0] TAG_VALUE  = 3'd1;
    localparam logic [2:0] TAG_LINE   = 3'd2;
    localparam logic [2:0] TAG_HDONE  = 3'd3;
    localparam logic [2:0] TAG_DATA   = 3'd4;
    localparam logic [2:0] TAG_PEND   = 3'd5;
    localparam logic [2:0] TAG_BEND   = 3'd6;
    localparam logic [2:0] TAG_STATUS = 3'd7;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_LIM  = 2'd2;

    localparam logic [2:0] MODE_BEGIN      = 3'd0;
    localparam logic [2:0] MODE_NAME_START = 3'd1;
    localparam logic [2:0] MODE_NAME       = 3'd2;
    localparam logic [2:0] MODE_NAME_GAP   = 3'd3;
    localparam logic [2:0] MODE_VALUE      = 3'd4;
    localparam logic [2:0] MODE_DATA       = 3'd5;
    localparam logic [2:0] MODE_STOP       = 3'd6;

    localparam logic [0:0] REG_BLEN  = 1'b0;
    localparam logic [0:0] REG_LIMIT = 1'b1;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
        logic [5:0] boundary_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0] tag;
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic       store_wr;
        logic       fetch;      // read delimiter byte at fetch_pos
        logic [6:0] fetch_pos;
        logic       fetch_end;  // closing-delimiter pattern
    } mfdp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [7:0] pat_byte;   // registered pattern byte
    } mfdp_sts_t;

    function automatic logic hdr_name_char(input logic [7:0] c);
        logic r;
        r = (c >= 8'd33) && (c <= 8'd126);
        case (c) inside
            8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h5c, 8'h22,
            8'h2f, 8'h5b, 8'h5d, 8'h3d, 8'h7b, 8'h7d, 8'h3f: r = 1'b0;
            default: ;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/mfdp_datapath.sv @@
// mfdp_datapath: boundary store and delimiter pattern byte generator
// depends on mfdp_pkg
module mfdp_datapath (
    input  logic                 aclk,
    input  logic [5:0]           blen,
    input  mfdp_pkg::mfdp_cmd_t  cmd,
    input  logic [7:0]           wr_byte,
    input  logic [5:0]           wr_index,
    output mfdp_pkg::mfdp_sts_t  sts
);

    logic [7:0] store_mem [mfdp_pkg::BOUNDARY_MAX];
    logic [7:0] rd_reg;
    logic [7:0] pat_reg;
    logic [7:0] pat_next;
    logic       use_rd_reg;
    logic [6:0] rel;
    logic [5:0] rd_addr;

    assign rel = cmd.fetch_pos - 7'd4;
    assign rd_addr = rel[5:0];

    always_comb begin
        use_rd_reg = 1'b0;
        pat_next = 8'h00;
        if (cmd.fetch_pos == 7'd0) begin
            pat_next = mfdp_pkg::CH_CR;
        end else if (cmd.fetch_pos == 7'd1) begin
            pat_next = mfdp_pkg::CH_LF;
        end else if (cmd.fetch_pos < 7'd4) begin
            pat_next = mfdp_pkg::CH_DASH;
        end else if (rel < {1'b0, blen}) begin
            use_rd_reg = 1'b1;
        end else if (!cmd.fetch_end) begin
            if (rel == {1'b0, blen}) pat_next = mfdp_pkg::CH_CR;
            else if (rel == {1'b0, blen} + 7'd1) pat_next = mfdp_pkg::CH_LF;
        end else begin
            if (rel < {1'b0, blen} + 7'd2) pat_next = mfdp_pkg::CH_DASH;
            else if (rel == {1'b0, blen} + 7'd2) pat_next = mfdp_pkg::CH_CR;
            else if (rel == {1'b0, blen} + 7'd3) pat_next = mfdp_pkg::CH_LF;
        end
    end

    logic use_reg;

    always_ff @(posedge aclk) begin
        if (cmd.store_wr && wr_index < 6'(mfdp_pkg::BOUNDARY_MAX))
            store_mem[wr_index] <= wr_byte;
        if (rd_addr < 6'(mfdp_pkg::BOUNDARY_MAX)) rd_reg <= store_mem[rd_addr];
        if (cmd.fetch) begin
            pat_reg <= pat_next;
            use_reg <= use_rd_reg;
        end
    end

    assign sts.pat_byte = use_reg ? rd_reg : pat_reg;

endmodule

@@ rtl/mfdp_ctrl.sv @@
// mfdp_ctrl: parse state machine, replay sequencer and result register
// depends on mfdp_pkg; drives mfdp_datapath through command signals
module mfdp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mfdp_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mfdp_pkg::out_item_t  m_data,
    input  logic [5:0]           blen,
    input  logic [31:0]          max_body_bytes,
    output mfdp_pkg::mfdp_cmd_t  cmd,
    input  mfdp_pkg::mfdp_sts_t  sts
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FETCH  = 3'd1;
    localparam logic [2:0] S_WAIT   = 3'd2;
    localparam logic [2:0] S_EVAL   = 3'd3;
    localparam logic [2:0] S_REPLAY = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  mode_reg, mode_next;
    logic [6:0]  pos_reg, pos_next;
    logic        endsus_reg, endsus_next;
    logic        crp_reg, crp_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [1:0]  stop_reg, stop_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  c_reg, c_next;
    logic [6:0]  rp_reg, rp_next;
    // queued results after replay: up to two
    mfdp_pkg::out_item_t q0_reg, q0_next, q1_reg, q1_next;
    logic [1:0]  qn_reg, qn_next;
    logic        ov_reg, ov_next;
    mfdp_pkg::out_item_t o_reg, o_next;
    logic        lim_reg, lim_next;

    logic [6:0] seplen, endlen;
    logic       lim_now, lim_after;
    logic       out_free;

    assign seplen = {1'b0, blen} + 7'd6;
    assign endlen = {1'b0, blen} + 7'd8;
    assign lim_now = (max_body_bytes != 32'd0) && (cnt_reg >= max_body_bytes);
    assign lim_after = (max_body_bytes != 32'd0) && (cnt_reg + 32'd1 >= max_body_bytes);
    assign out_free = !ov_reg || m_ready;
    assign s_ready = (state_reg == S_IDLE) && out_free;
    assign m_valid = ov_reg;
    assign m_data = o_reg;

    function automatic mfdp_pkg::out_item_t mk(input logic [2:0] t, input logic [7:0] b,
                                               input logic [1:0] s, input logic l);
        mfdp_pkg::out_item_t r;
        r.tag = t;
        r.out_byte = b;
        r.status = s;
        r.last = l;
        return r;
    endfunction

    always_comb begin
        logic [7:0] c;
        logic       pm;
        logic [2:0] nq;
        mfdp_pkg::out_item_t r [3];
        c = c_reg;
        pm = (sts.pat_byte == c);
        nq = 3'd0;
        r[0] = mk(mfdp_pkg::TAG_STATUS, 8'h00, 2'd0, 1'b1);
        r[1] = r[0];
        r[2] = r[0];
        state_next = state_reg;
        mode_next = mode_reg;
        pos_next = pos_reg;
        endsus_next = endsus_reg;
        crp_next = crp_reg;
        cnt_next = cnt_reg;
        stop_next = stop_reg;
        kind_next = kind_reg;
        c_next = c_reg;
        rp_next = rp_reg;
        q0_next = q0_reg;
        q1_next = q1_reg;
        qn_next = qn_reg;
        lim_next = lim_reg;
        ov_next = ov_reg && !m_ready;
        o_next = o_reg;
        cmd.store_wr = 1'b0;
        cmd.fetch = 1'b0;
        cmd.fetch_pos = pos_reg;
        cmd.fetch_end = endsus_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    kind_next = s_data.kind;
                    c_next = s_data.byte_value;
                    unique case (s_data.kind) inside
                        mfdp_pkg::KIND_LOAD: cmd.store_wr = 1'b1;
                        mfdp_pkg::KIND_BYTE, mfdp_pkg::KIND_END: begin
                            if (mode_reg == mfdp_pkg::MODE_STOP) begin
                                ov_next = 1'b1;
                                o_next = mk(mfdp_pkg::TAG_STATUS, 8'h00, stop_reg, 1'b1);
                            end else if (lim_now) begin
                                mode_next = mfdp_pkg::MODE_STOP;
                                stop_next = mfdp_pkg::ST_LIM;
                                ov_next = 1'b1;
                                o_next = mk(mfdp_pkg::TAG_STATUS, 8'h00,
                                            mfdp_pkg::ST_LIM, 1'b1);
                            end else begin
                                state_next = S_FETCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FETCH: begin
                cmd.fetch = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT: state_next = S_EVAL;
            S_EVAL: begin
                if (kind_reg == mfdp_pkg::KIND_END) begin
                    mode_next = mfdp_pkg::MODE_STOP;
                    if (mode_reg == mfdp_pkg::MODE_DATA && endsus_reg &&
                        pos_reg == seplen) begin
                        stop_next = mfdp_pkg::ST_OK;
                        r[0] = mk(mfdp_pkg::TAG_PEND, 8'h00, 2'd0, 1'b0);
                        r[1] = mk(mfdp_pkg::TAG_BEND, 8'h00, 2'd0, 1'b1);
                        nq = 3'd2;
                    end else begin
                        stop_next = mfdp_pkg::ST_BAD;
                        nq = 3'd1;
                        r[0] = mk(mfdp_pkg::TAG_STATUS, 8'h00, mfdp_pkg::ST_BAD, 1'b1);
                    end
                    lim_next = 1'b0;
                end else begin
                    logic replay;
                    replay = 1'b0;
                    lim_next = lim_after;
                    cnt_next = cnt_reg + 32'd1;
                    unique case (mode_reg)
                        mfdp_pkg::MODE_BEGIN: begin
                            if (!pm) pos_next = 7'd0;
                            else begin
                                pos_next = pos_reg + 7'd1;
                                if (pos_reg + 7'd1 == seplen)
                                    mode_next = mfdp_pkg::MODE_NAME_START;
                            end
                        end
                        mfdp_pkg::MODE_NAME_START: begin
                            if (crp_reg) begin
                                if (c != mfdp_pkg::CH_LF) begin
                                    mode_next = mfdp_pkg::MODE_STOP;
                                    stop_next = mfdp_pkg::ST_BAD;
                                    r[0] = mk(mfdp_pkg::TAG_STATUS, 8'h00,
                                              mfdp_pkg::ST_BAD, 1'b0);
                                    nq = 3'd1;
                                end else begin
                                    crp_next = 1'b0;
                                    pos_next = 7'd0;
                                    mode_next = mfdp_pkg::MODE_DATA;
                                    r[0] = mk(mfdp_pkg::TAG_HDONE, 8'h00, 2'd0, 1'b0);
                                    nq = 3'd1;
                                end
                            end else if (c == mfdp_pkg::CH_CR) begin
                                crp_next = 1'b1;
                            end else if (mfdp_pkg::hdr_name_char(c)) begin
                                r[0] = mk(mfdp_pkg::TAG_NAME, c, 2'd0, 1'b0);
                                nq = 3'd1;
                                mode_next = mfdp_pkg::MODE_NAME;
                            end else begin
                                mode_next = mfdp_pkg::MODE_STOP;
                                stop_next = mfdp_pkg::ST_BAD;
                                r[0] = mk(mfdp_pkg::TAG_STATUS, 8'h00, mfdp_pkg::ST_BAD, 1'b0);
                                nq = 3'd1;
                            end
                        end
                        mfdp_pkg::MODE_NAME: begin
                            if (c == mfdp_pkg::CH_COLON) mode_next = mfdp_pkg::MODE_VALUE;
                            else if (c == mfdp_pkg::CH_SP || c == mfdp_pkg::CH_TAB)
                                mode_next = mfdp_pkg::MODE_NAME_GAP;
                            else if (mfdp_pkg::hdr_name_char(c)) begin
                                r[0] = mk(mfdp_pkg::TAG_NAME, c, 2'd0, 1'b0);
                                nq = 3'd1;
                            end else begin
                                mode_next = mfdp_pkg::MODE_STOP;
                                stop_next = mfdp_pkg::ST_BAD;
                                r[0] = mk(mfdp_pkg::TAG_STATUS, 8'h00, mfdp_pkg::ST_BAD, 1'b0);
                                nq = 3'd1;
                            end
                        end
                        mfdp_pkg::MODE_NAME_GAP: begin
                            if (c == mfdp_pkg::CH_COLON) mode_next = mfdp_pkg::MODE_VALUE;
                            else if (c != mfdp_pkg::CH_SP && c != mfdp_pkg::CH_TAB) begin
                                mode_next = mfdp_pkg::MODE_STOP;
                                stop_next = mfdp_pkg::ST_BAD;
                                r[0] = mk(mfdp_pkg::TAG_STATUS, 8'h00, mfdp_pkg::ST_BAD, 1'b0);
                                nq = 3'd1;
                            end
                        end
                        mfdp_pkg::MODE_VALUE: begin
                            if (crp_reg) begin
                                crp_next = 1'b0;
                                if (c == mfdp_pkg::CH_LF) begin
                                    r[0] = mk(mfdp_pkg::TAG_LINE, 8'h00, 2'd0, 1'b0);
                                    nq = 3'd1;
                                    mode_next = mfdp_pkg::MODE_NAME_START;
                                end else begin
                                    r[0] = mk(mfdp_pkg::TAG_VALUE, mfdp_pkg::CH_CR, 2'd0, 1'b0);
                                    r[1] = mk(mfdp_pkg::TAG_VALUE, c, 2'd0, 1'b0);
                                    nq = 3'd2;
                                end
                            end else if (c == mfdp_pkg::CH_CR) begin
                                crp_next = 1'b1;
                            end else begin
                                r[0] = mk(mfdp_pkg::TAG_VALUE, c, 2'd0, 1'b0);
                                nq = 3'd1;
                            end
                        end
                        mfdp_pkg::MODE_DATA: begin
                            if (endsus_reg) begin
                                if (!pm) replay = 1'b1;
                                else begin
                                    pos_next = pos_reg + 7'd1;
                                    if (pos_reg + 7'd1 == endlen) begin
                                        r[0] = mk(mfdp_pkg::TAG_PEND, 8'h00, 2'd0, 1'b0);
                                        r[1] = mk(mfdp_pkg::TAG_BEND, 8'h00, 2'd0, 1'b0);
                                        nq = 3'd2;
                                        mode_next = mfdp_pkg::MODE_STOP;
                                        stop_next = mfdp_pkg::ST_OK;
                                    end
                                end
                            end else if (pm) begin
                                pos_next = pos_reg + 7'd1;
                                if (pos_reg + 7'd1 == seplen) begin
                                    r[0] = mk(mfdp_pkg::TAG_PEND, 8'h00, 2'd0, 1'b0);
                                    nq = 3'd1;
                                    mode_next = mfdp_pkg::MODE_NAME_START;
                                end
                            end else if (pos_reg == seplen - 7'd2 && c == mfdp_pkg::CH_DASH) begin
                                endsus_next = 1'b1;
                                pos_next = pos_reg + 7'd1;
                            end else begin
                                replay = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    if (replay) begin
                        if (c != mfdp_pkg::CH_CR) begin
                            r[0] = mk(mfdp_pkg::TAG_DATA, c, 2'd0, 1'b0);
                            nq = 3'd1;
                        end
                    end
                    if (lim_after) begin
                        mode_next = mfdp_pkg::MODE_STOP;
                        stop_next = mfdp_pkg::ST_LIM;
                        if (nq == 3'd0 && !(replay && pos_reg != 7'd0)) begin
                            r[0] = mk(mfdp_pkg::TAG_STATUS, 8'h00, mfdp_pkg::ST_LIM, 1'b0);
                            nq = 3'd1;
                        end
                    end
                    if (replay && pos_reg != 7'd0) begin
                        rp_next = 7'd0;
                        state_next = S_REPLAY;
                    end
                end
                q0_next = r[0];
                q1_next = r[1];
                qn_next = nq[1:0];
                if (state_next != S_REPLAY) state_next = S_EMIT;
            end
            S_REPLAY: begin
                // delimiter bytes are fetched one at a time and sent as data while the result register is free
                cmd.fetch_pos = rp_reg;
                if (!ov_reg || m_ready) begin
                    if (crp_reg) begin
                        ov_next = 1'b1;
                        o_next = mk(mfdp_pkg::TAG_DATA, sts.pat_byte, 2'd0, 1'b0);
                        crp_next = 1'b0;
                        rp_next = rp_reg + 7'd1;
                        if (rp_reg + 7'd1 == pos_reg) begin
                            if (qn_reg == 2'd0 && lim_reg) begin
                                o_next.status = mfdp_pkg::ST_LIM;
                                o_next.last = 1'b1;
                            end else if (qn_reg == 2'd0) begin
                                o_next.last = 1'b1;
                            end
                            pos_next = (c == mfdp_pkg::CH_CR) ? 7'd1 : 7'd0;
                            endsus_next = 1'b0;
                            state_next = S_EMIT;
                        end
                    end else begin
                        cmd.fetch = 1'b1;
                        crp_next = 1'b1;
                    end
                end
            end
            S_EMIT: begin
                if (qn_reg == 2'd0) state_next = S_IDLE;
                else if (!ov_reg || m_ready) begin
                    ov_next = 1'b1;
                    o_next = q0_reg;
                    if (qn_reg == 2'd1) begin
                        o_next.last = 1'b1;
                        if (lim_reg) begin
                            o_next.status = mfdp_pkg::ST_LIM;
                            if (q0_reg.tag == mfdp_pkg::TAG_BEND)
                                o_next.tag = mfdp_pkg::TAG_STATUS;
                        end
                    end
                    q0_next = q1_reg;
                    qn_next = qn_reg - 2'd1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mode_reg <= mfdp_pkg::MODE_BEGIN;
            pos_reg <= 7'd2;
            endsus_reg <= 1'b0;
            crp_reg <= 1'b0;
            cnt_reg <= 32'd0;
            stop_reg <= mfdp_pkg::ST_OK;
            ov_reg <= 1'b0;
            qn_reg <= 2'd0;
            lim_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mode_reg <= mode_next;
            pos_reg <= pos_next;
            endsus_reg <= endsus_next;
            crp_reg <= crp_next;
            cnt_reg <= cnt_next;
            stop_reg <= stop_next;
            ov_reg <= ov_next;
            qn_reg <= qn_next;
            lim_reg <= lim_next;
        end
        kind_reg <= kind_next;
        c_reg <= c_next;
        rp_reg <= rp_next;
        q0_reg <= q0_next;
        q1_reg <= q1_next;
        o_reg <= o_next;
    end

endmodule

@@ rtl/multipart_form_data_parser_core.sv @@
// multipart_form_data_parser_core: top level of the multipart form-data parser
// depends on mfdp_pkg, mfdp_ctrl and mfdp_datapath
//
//  channel   ports                   direction  payload
//  input     s_valid/s_ready/s_data  in         mfdp_pkg::in_item_t
//  result    m_valid/m_ready/m_data  out        mfdp_pkg::out_item_t
//  config    cfg_wr/cfg_index/cfg_data  in      32-bit register data
//
// a body byte passes the fetch, wait and eval states, then emits its results; a broken
// delimiter match replays its bytes as data
// aresetn is synchronous and clears all control state
// the boundary store is not cleared; a stalled result register holds the sequencer
module multipart_form_data_parser_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mfdp_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mfdp_pkg::out_item_t  m_data,
    input  logic                 cfg_wr,
    input  logic [0:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    logic [5:0]  blen_reg;
    logic [31:0] limit_reg;
    logic [5:0]  blen_eff;
    mfdp_pkg::mfdp_cmd_t cmd;
    mfdp_pkg::mfdp_sts_t sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blen_reg <= 6'd1;
            limit_reg <= 32'd0;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                mfdp_pkg::REG_BLEN:  blen_reg <= cfg_data[5:0];
                mfdp_pkg::REG_LIMIT: limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign blen_eff = (blen_reg > 6'(mfdp_pkg::BOUNDARY_MAX)) ?
                      6'(mfdp_pkg::BOUNDARY_MAX) : blen_reg;

    mfdp_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .blen(blen_eff), .max_body_bytes(limit_reg), .cmd, .sts
    );

    mfdp_datapath u_dp (
        .aclk, .blen(blen_eff), .cmd, .wr_byte(s_data.byte_value),
        .wr_index(s_data.boundary_index), .sts
    );

endmodule

@@ rtl/mfdp_checker.sv @@
// mfdp_checker: port-level assertions for the parser top level
// depends on mfdp_pkg; bound to multipart_form_data_parser_core
module mfdp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input mfdp_pkg::out_item_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped under stall");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != mfdp_pkg::ST_OK |-> m_data.last)
        else $error("status on non-last result");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status != 2'd3)
        else $error("bad status code");

    a_status_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.tag == mfdp_pkg::TAG_STATUS && m_data.status == mfdp_pkg::ST_OK
        |-> m_data.last)
        else $error("status result not last");

endmodule

bind multipart_form_data_parser_core mfdp_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_data
);
